[design/oms_pkg.sv]
`timescale 1ns / 1ps
// types and constants shared by the overdue message scheduler modules
package oms_pkg;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int SLOT_W   = 4;
	localparam int TIME_W   = 64;
	localparam int PERIOD_W = 32;
	localparam int ACTIVE_W = 5;
	localparam int STATUS_W = 2;

	// request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_TRIGGER = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_DIRECT  = 2'd2,
		OP_LOAD    = 2'd3
	} opcode_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_BAD_SLOT  = 2'd1,
		STS_RING_FULL = 2'd2
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DRAIN,
		S_SCAN,
		S_WAIT,
		S_RESULT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    latch;
		logic    push;
		logic    pop;
		logic    load_period;
		logic    sel_clear;
		logic    direct_issue;
		logic    scan_start;
		logic    scan_issue;
		logic    stamp;
		logic    res_load;
		logic    res_scan;
		status_t res_status;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		opcode_t opcode;
		logic    slot_ok;
		logic    ring_empty;
		logic    ring_full;
		logic    lim_zero;
		logic    scan_last;
		logic    pipe_busy;
	} stat_t;

endpackage

[design/overdue_message_scheduler.sv]
`timescale 1ns / 1ps
// top level of the overdue message scheduler
//
// channel   direction  handshake                payload
// item      in         item_valid / item_stall  opcode, slot, cur_time, period_len
// result    out        result_valid / result_stall  status, sent, chosen_slot,
//                                                   overdue_amount
// cfg       in         cfg_valid / cfg_ready    cfg_data (active slot count)
//
// trigger and period load pass through the decode and result states to the result register.
// direct send adds one table read and three scan pipeline stages.
// update drains the D pending ring entries one per cycle, then issues the S
// active slots one per cycle into the scan pipeline.
// reset clears all tables by per-slot written marks; no clearing pass.
// a stalled result is held while the next item is already being worked on.
module overdue_message_scheduler
	import oms_pkg::*;
#(
	parameter int MAX_SLOTS  = 16,
	parameter int RING_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [OP_W-1:0]     opcode,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [TIME_W-1:0]   cur_time,
	input  logic [PERIOD_W-1:0] period_len,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [STATUS_W-1:0] status,
	output logic                sent,
	output logic [SLOT_W-1:0]   chosen_slot,
	output logic [TIME_W-1:0]   overdue_amount,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ACTIVE_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	// controller
	oms_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.stat        (stat),
		.cmd         (cmd)
	);

	// datapath
	oms_dpath #(
		.MAX_SLOTS (MAX_SLOTS),
		.RING_DEPTH(RING_DEPTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.slot          (slot),
		.cur_time      (cur_time),
		.period_len    (period_len),
		.status        (status),
		.sent          (sent),
		.chosen_slot   (chosen_slot),
		.overdue_amount(overdue_amount)
	);

endmodule

[design/oms_ram.sv]
`timescale 1ns / 1ps
// generic single write port ram with registered read
module oms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/oms_dpath.sv]
`timescale 1ns / 1ps
// scheduler datapath: tables, trigger ring, scan pipeline and result register
module oms_dpath
	import oms_pkg::*;
#(
	parameter int MAX_SLOTS  = 16,
	parameter int RING_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic                cfg_we,
	input  logic [ACTIVE_W-1:0] cfg_data,
	input  logic [OP_W-1:0]     opcode,
	input  logic [SLOT_W-1:0]   slot,
	input  logic [TIME_W-1:0]   cur_time,
	input  logic [PERIOD_W-1:0] period_len,
	output logic [STATUS_W-1:0] status,
	output logic                sent,
	output logic [SLOT_W-1:0]   chosen_slot,
	output logic [TIME_W-1:0]   overdue_amount
);

	localparam int IDX_W  = $clog2(MAX_SLOTS);
	localparam int RW     = $clog2(RING_DEPTH);
	localparam int LIM_B  = $clog2(MAX_SLOTS + 1);
	localparam int CW     = (LIM_B > ACTIVE_W) ? LIM_B : ACTIVE_W;

	// configuration and latched request
	logic [ACTIVE_W-1:0] active_q;
	opcode_t             opcode_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [TIME_W-1:0]   uptime_q;
	logic [PERIOD_W-1:0] period_q;

	// per-slot state
	logic [MAX_SLOTS-1:0] flags_q;
	logic [MAX_SLOTS-1:0] per_vld_q;
	logic [MAX_SLOTS-1:0] ls_vld_q;

	// ring pointers and drain stage
	logic [RW-1:0]     head_q, tail_q, head_nxt, tail_nxt;
	logic              drain_vld_s1;
	logic [SLOT_W-1:0] ring_rd;

	// scan pipeline
	logic [IDX_W-1:0]    cnt_q, tbl_addr, slot_idx;
	logic                issue;
	logic                vld_s1, vld_s2, vld_s3;
	logic [IDX_W-1:0]    idx_s1, idx_s2, idx_s3;
	logic [PERIOD_W-1:0] per_rd, per_eff, per_s2;
	logic [TIME_W-1:0]   last_rd, last_eff, elapsed_s2, cand_s3;
	logic                flag_s2, flag_s3, due_s3, per_nz_s3;
	logic [TIME_W:0]     diff;

	// selection state
	logic                direct_q, have_q, trig_q, take;
	logic [TIME_W-1:0]   best_q;
	logic [IDX_W-1:0]    pick_q;

	// result register
	status_t             res_status_q;
	logic                res_sent_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [TIME_W-1:0]   res_amount_q;

	logic [CW-1:0]       lim, act_w;

	// effective slot limit
	assign act_w = CW'(active_q);
	assign lim   = (act_w > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : act_w;

	assign slot_idx = IDX_W'(slot_q);
	assign head_nxt = (head_q == RW'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == RW'(RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// status to controller
	assign stat.opcode     = opcode_q;
	assign stat.slot_ok    = CW'(slot_q) < lim;
	assign stat.ring_empty = head_q == tail_q;
	assign stat.ring_full  = head_nxt == tail_q;
	assign stat.lim_zero   = lim == '0;
	assign stat.scan_last  = CW'(cnt_q) == (lim - CW'(1));
	assign stat.pipe_busy  = vld_s1 | vld_s2 | vld_s3;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			opcode_q <= opcode_t'(opcode);
			slot_q   <= slot;
			uptime_q <= cur_time;
			period_q <= period_len;
		end
	end

	// trigger ring storage
	oms_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(head_q),
		.wdata(slot_q),
		.raddr(tail_q),
		.rdata(ring_rd)
	);

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			drain_vld_s1 <= 1'b0;
		end else begin
			if (cmd.push) begin
				head_q <= head_nxt;
			end
			if (cmd.pop) begin
				tail_q <= tail_nxt;
			end
			drain_vld_s1 <= cmd.pop;
		end
	end

	// table read address: scan counter or direct slot
	assign tbl_addr = cmd.direct_issue ? slot_idx : cnt_q;
	assign issue    = cmd.direct_issue | cmd.scan_issue;

	oms_ram #(
		.WIDTH(PERIOD_W),
		.DEPTH(MAX_SLOTS)
	) u_period (
		.clk  (clk),
		.we   (cmd.load_period),
		.waddr(slot_idx),
		.wdata(period_q),
		.raddr(tbl_addr),
		.rdata(per_rd)
	);

	oms_ram #(
		.WIDTH(TIME_W),
		.DEPTH(MAX_SLOTS)
	) u_last (
		.clk  (clk),
		.we   (cmd.stamp & have_q),
		.waddr(pick_q),
		.wdata(uptime_q),
		.raddr(tbl_addr),
		.rdata(last_rd)
	);

	// per-slot flags and written marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			per_vld_q <= '0;
			ls_vld_q  <= '0;
		end else begin
			if (drain_vld_s1 && (CW'(ring_rd) < CW'(MAX_SLOTS))) begin
				flags_q[IDX_W'(ring_rd)] <= 1'b1;
			end
			if (cmd.stamp && have_q) begin
				flags_q[pick_q]  <= 1'b0;
				ls_vld_q[pick_q] <= 1'b1;
			end
			if (cmd.load_period) begin
				per_vld_q[slot_idx] <= 1'b1;
			end
		end
	end

	// scan counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scan_start) begin
			cnt_q <= '0;
		end else if (cmd.scan_issue) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// unwritten entries read as zero
	assign per_eff  = per_vld_q[idx_s1] ? per_rd : '0;
	assign last_eff = ls_vld_q[idx_s1] ? last_rd : '0;
	assign diff     = {1'b0, elapsed_s2} - {{(TIME_W - PERIOD_W + 1){1'b0}}, per_s2};

	// scan pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// scan pipeline payload: elapsed time, then overdue
	always_ff @(posedge clk) begin
		idx_s1     <= tbl_addr;
		elapsed_s2 <= uptime_q - last_eff;
		per_s2     <= per_eff;
		flag_s2    <= flags_q[idx_s1];
		idx_s2     <= idx_s1;
		due_s3     <= ~diff[TIME_W];
		cand_s3    <= diff[TIME_W] ? '0 : diff[TIME_W-1:0];
		per_nz_s3  <= per_s2 != '0;
		flag_s3    <= flag_s2;
		idx_s3     <= idx_s2;
	end

	// candidate selection: a direct send takes its slot; else triggered slots first, ties to the later slot
	always_comb begin
		take = 1'b0;
		if (vld_s3) begin
			if (direct_q) begin
				take = 1'b1;
			end else if (flag_s3) begin
				take = !trig_q || (cand_s3 >= best_q);
			end else begin
				take = !trig_q && per_nz_s3 && due_s3 && (cand_s3 >= best_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_q <= 1'b0;
			have_q   <= 1'b0;
			trig_q   <= 1'b0;
			best_q   <= '0;
			pick_q   <= '0;
		end else if (cmd.sel_clear) begin
			direct_q <= cmd.direct_issue;
			have_q   <= 1'b0;
			trig_q   <= 1'b0;
			best_q   <= '0;
			pick_q   <= '0;
		end else if (take) begin
			have_q <= 1'b1;
			best_q <= cand_s3;
			pick_q <= idx_s3;
			if (flag_s3) begin
				trig_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_sent_q   <= cmd.res_scan & have_q;
			res_slot_q   <= (cmd.res_scan & have_q) ? SLOT_W'(pick_q) : '0;
			res_amount_q <= (cmd.res_scan & have_q) ? best_q : '0;
		end
	end

	assign status         = res_status_q;
	assign sent           = res_sent_q;
	assign chosen_slot    = res_slot_q;
	assign overdue_amount = res_amount_q;

endmodule

[design/oms_ctrl.sv]
`timescale 1ns / 1ps
// scheduler controller: request sequencing and result handshake
module oms_ctrl
	import oms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_stall,
	output logic  result_valid,
	input  logic  result_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t  state_q, state_nxt;
	status_t status_q, status_nxt;
	logic    scan_q, scan_nxt;
	logic    out_valid_q;

	assign item_stall   = state_q != S_IDLE;
	assign result_valid = out_valid_q;

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= STS_OK;
			scan_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			status_q <= status_nxt;
			scan_q   <= scan_nxt;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_nxt      = state_q;
		status_nxt     = status_q;
		scan_nxt       = scan_q;
		cmd            = '0;
		cmd.res_status = status_q;
		cmd.res_scan   = scan_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				status_nxt = STS_OK;
				scan_nxt   = 1'b0;
				state_nxt  = S_RESULT;
				unique case (stat.opcode)
					OP_TRIGGER: begin
						if (!stat.slot_ok) begin
							status_nxt = STS_BAD_SLOT;
						end else if (stat.ring_full) begin
							status_nxt = STS_RING_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					OP_UPDATE: begin
						cmd.sel_clear = 1'b1;
						scan_nxt      = 1'b1;
						state_nxt     = S_DRAIN;
					end
					OP_DIRECT: begin
						if (!stat.slot_ok) begin
							status_nxt = STS_BAD_SLOT;
						end else begin
							cmd.sel_clear    = 1'b1;
							cmd.direct_issue = 1'b1;
							scan_nxt         = 1'b1;
							state_nxt        = S_WAIT;
						end
					end
					OP_LOAD: begin
						if (!stat.slot_ok) begin
							status_nxt = STS_BAD_SLOT;
						end else begin
							cmd.load_period = 1'b1;
						end
					end
					default: begin
						status_nxt = STS_OK;
					end
				endcase
			end
			S_DRAIN: begin
				// move pending triggers into the flags, then start the scan
				if (!stat.ring_empty) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.scan_start = 1'b1;
					state_nxt      = stat.lim_zero ? S_WAIT : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.scan_last) begin
					state_nxt = S_WAIT;
				end
			end
			S_WAIT: begin
				// stamp the chosen slot once the pipeline is empty
				if (!stat.pipe_busy) begin
					cmd.stamp = 1'b1;
					state_nxt = S_RESULT;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || !result_stall) begin
					cmd.res_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule
